>>> src/sqlop_pkg.sv
// Package for the SQL operator token scanner.
// Holds character codes, scan phase and class codes, state and result
// structs, and character class functions. No dependencies.
package sqlop_pkg;

  // default bound on the token length
  localparam int unsigned MaxTokenLenDefault = 63;

  // result field widths
  localparam int unsigned LenW   = 6;
  localparam int unsigned BlankW = 8;
  localparam int unsigned MaskW  = 4;

  // character codes
  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharStar  = 8'h2A;
  localparam logic [7:0] CharSlash = 8'h2F;
  localparam logic [7:0] CharLt    = 8'h3C;
  localparam logic [7:0] CharGt    = 8'h3E;
  localparam logic [7:0] CharEq    = 8'h3D;
  localparam logic [7:0] CharTilde = 8'h7E;
  localparam logic [7:0] CharBang  = 8'h21;
  localparam logic [7:0] CharAt    = 8'h40;
  localparam logic [7:0] CharHash  = 8'h23;
  localparam logic [7:0] CharPct   = 8'h25;
  localparam logic [7:0] CharCaret = 8'h5E;
  localparam logic [7:0] CharAmp   = 8'h26;
  localparam logic [7:0] CharPipe  = 8'h7C;
  localparam logic [7:0] CharTick  = 8'h60;
  localparam logic [7:0] CharQuest = 8'h3F;

  // token classes, also the bit index into the class mask
  localparam logic [1:0] ClsCmp   = 2'd0;
  localparam logic [1:0] ClsPm    = 2'd1;
  localparam logic [1:0] ClsMd    = 2'd2;
  localparam logic [1:0] ClsOther = 2'd3;

  // bit positions of the per-character class flags
  localparam int unsigned FlCmp = 0;
  localparam int unsigned FlPm  = 1;
  localparam int unsigned FlMd  = 2;

  typedef enum logic [1:0] {
    PhIdle  = 2'd0,
    PhBlank = 2'd1,
    PhOper  = 2'd2,
    PhDone  = 2'd3
  } phase_e;

  // scan state of fixed width (counters live beside it)
  typedef struct packed {
    phase_e            phase;
    logic [6:0]        prev_char;
    logic              seen_special;
    logic [2:0]        pend_flags;
    logic [2:0]        acc_flags;
    logic [BlankW-1:0] blank_count;
    logic [MaskW-1:0]  mask;
  } scan_state_t;

  typedef struct packed {
    logic              found;
    logic [1:0]        token_class;
    logic [LenW-1:0]   token_length;
    logic [BlankW-1:0] blanks_skipped;
    logic              overlong;
  } scan_result_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CharSpace) || (c == CharTab) || (c == CharCr) || (c == CharLf);
  endfunction

  function automatic logic is_special(input logic [7:0] c);
    logic hit;
    case (c)
      CharTilde, CharBang, CharAt, CharHash, CharPct,
      CharCaret, CharAmp, CharPipe, CharTick, CharQuest: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic logic is_op_char(input logic [7:0] c);
    logic hit;
    case (c)
      CharPlus, CharMinus, CharStar, CharSlash, CharLt, CharGt, CharEq: hit = 1'b1;
      default: hit = is_special(c);
    endcase
    return hit;
  endfunction

  // two-character comparison operators, or a lone compare char at token start
  function automatic logic pair_is_cmp(input logic [7:0] a, input logic [7:0] b);
    logic hit;
    if (a == CharNul) begin
      hit = (b == CharLt) || (b == CharGt) || (b == CharEq);
    end else begin
      hit = ((a == CharLt) && (b == CharEq)) || ((a == CharLt) && (b == CharGt)) ||
            ((a == CharBang) && (b == CharEq)) || ((a == CharGt) && (b == CharEq));
    end
    return hit;
  endfunction

endpackage

>>> src/sql_operator_token_scanner.sv
// SQL operator token scanner, top level: scan state registers and result register.
// A result appears in the result register in the cycle after its ending character.
// One character per cycle while in_ready_o is high; scan state updates on every accepted
// character, the result register loads on an ending character and frees on take.
// Reset: asynchronous, active low; scan idle, counters cleared, no result pending.
// Depends on sqlop_pkg and sqlop_step.
module sql_operator_token_scanner #(
  parameter int unsigned MAX_TOKEN_LEN = sqlop_pkg::MaxTokenLenDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        start_scan_i,
  input  logic [7:0]  char_code_i,
  input  logic [3:0]  valid_mask_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        found_o,
  output logic [1:0]  token_class_o,
  output logic [5:0]  token_length_o,
  output logic [7:0]  blanks_skipped_o,
  output logic        overlong_o
);

  localparam int unsigned CntW = $clog2(MAX_TOKEN_LEN + 1);

  sqlop_pkg::scan_state_t  state_q, state_d;
  sqlop_pkg::scan_result_t result_q, result_d;
  logic [CntW-1:0]         consumed_q, consumed_d;
  logic [CntW-1:0]         accepted_q, accepted_d;
  logic                    out_valid_q;
  logic                    emit;
  logic                    in_fire;

  // accept while the result register is empty or being emptied
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  sqlop_step #(
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
  ) u_step (
    .state_i      (state_q),
    .consumed_i   (consumed_q),
    .accepted_i   (accepted_q),
    .start_scan_i (start_scan_i),
    .char_code_i  (char_code_i),
    .valid_mask_i (valid_mask_i),
    .state_o      (state_d),
    .consumed_o   (consumed_d),
    .accepted_o   (accepted_d),
    .emit_o       (emit),
    .result_o     (result_d)
  );

  // scan state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase        <= sqlop_pkg::PhIdle;
      state_q.prev_char    <= 7'd0;
      state_q.seen_special <= 1'b0;
      state_q.pend_flags   <= 3'd0;
      state_q.acc_flags    <= 3'd0;
      state_q.blank_count  <= '0;
      state_q.mask         <= '0;
      consumed_q           <= '0;
      accepted_q           <= '0;
      out_valid_q          <= 1'b0;
    end else begin
      if (in_fire) begin
        state_q    <= state_d;
        consumed_q <= consumed_d;
        accepted_q <= accepted_d;
      end
      if (in_fire && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign found_o          = result_q.found;
  assign token_class_o    = result_q.token_class;
  assign token_length_o   = result_q.token_length;
  assign blanks_skipped_o = result_q.blanks_skipped;
  assign overlong_o       = result_q.overlong;

endmodule

>>> src/sqlop_step.sv
// Next-state and result logic of the operator scanner for one character.
// Purely combinational; depends on sqlop_pkg.
module sqlop_step #(
  parameter int unsigned MAX_TOKEN_LEN = sqlop_pkg::MaxTokenLenDefault,
  localparam int unsigned CntW = $clog2(MAX_TOKEN_LEN + 1)
) (
  input  sqlop_pkg::scan_state_t  state_i,
  input  logic [CntW-1:0]         consumed_i,
  input  logic [CntW-1:0]         accepted_i,
  input  logic                    start_scan_i,
  input  logic [7:0]              char_code_i,
  input  logic [3:0]              valid_mask_i,
  output sqlop_pkg::scan_state_t  state_o,
  output logic [CntW-1:0]         consumed_o,
  output logic [CntW-1:0]         accepted_o,
  output logic                    emit_o,
  output sqlop_pkg::scan_result_t result_o
);

  sqlop_pkg::scan_state_t st;
  logic [CntW-1:0] cons;
  logic [CntW-1:0] acc;
  logic [7:0]      last;
  logic [2:0]      flags;
  logic            stop;
  logic            over;
  logic [1:0]      cls;

  always_comb begin
    st    = state_i;
    cons  = consumed_i;
    acc   = accepted_i;
    stop  = 1'b0;
    over  = 1'b0;
    flags = 3'd0;
    cls   = sqlop_pkg::ClsCmp;
    last  = 8'd0;

    // start mark clears the scan and latches the class mask
    if (start_scan_i) begin
      st.phase        = sqlop_pkg::PhBlank;
      st.prev_char    = 7'd0;
      st.seen_special = 1'b0;
      st.pend_flags   = 3'd0;
      st.acc_flags    = 3'd0;
      st.blank_count  = '0;
      st.mask         = valid_mask_i;
      cons            = '0;
      acc             = '0;
    end

    // leading blanks, saturating count
    if (st.phase == sqlop_pkg::PhBlank) begin
      if (sqlop_pkg::is_blank(char_code_i)) begin
        if (st.blank_count != '1) begin
          st.blank_count = st.blank_count + 1'b1;
        end
      end else begin
        st.phase = sqlop_pkg::PhOper;
      end
    end

    // operator run
    if (st.phase == sqlop_pkg::PhOper) begin
      last = {1'b0, st.prev_char};
      if (((last == sqlop_pkg::CharMinus) && (char_code_i == sqlop_pkg::CharMinus)) ||
          ((last == sqlop_pkg::CharSlash) && (char_code_i == sqlop_pkg::CharStar))) begin
        stop = 1'b1;
      end else begin
        if (sqlop_pkg::is_special(last)) begin
          st.seen_special = 1'b1;
        end
        // a multi-char token may end in plus or minus only after a special char
        if (st.seen_special ||
            !((last == sqlop_pkg::CharPlus) || (last == sqlop_pkg::CharMinus)) ||
            (cons <= CntW'(1))) begin
          acc          = cons;
          st.acc_flags = st.pend_flags;
        end
        if (sqlop_pkg::is_op_char(char_code_i)) begin
          if (cons >= CntW'(MAX_TOKEN_LEN)) begin
            stop = 1'b1;
            over = 1'b1;
          end else begin
            cons = cons + 1'b1;
            flags[sqlop_pkg::FlCmp] = sqlop_pkg::pair_is_cmp(last, char_code_i);
            flags[sqlop_pkg::FlPm]  = (char_code_i == sqlop_pkg::CharPlus) ||
                                      (char_code_i == sqlop_pkg::CharMinus);
            flags[sqlop_pkg::FlMd]  = (char_code_i == sqlop_pkg::CharStar) ||
                                      (char_code_i == sqlop_pkg::CharSlash) ||
                                      (char_code_i == sqlop_pkg::CharPct);
            st.pend_flags = flags;
            st.prev_char  = char_code_i[6:0];
          end
        end else begin
          stop = 1'b1;
        end
      end
    end

    if (stop) begin
      st.phase = sqlop_pkg::PhDone;
    end

    // class of the accepted token
    if (acc != '0) begin
      if ((acc <= CntW'(2)) && st.acc_flags[sqlop_pkg::FlCmp]) begin
        cls = sqlop_pkg::ClsCmp;
      end else if ((acc == CntW'(1)) && st.acc_flags[sqlop_pkg::FlPm]) begin
        cls = sqlop_pkg::ClsPm;
      end else if ((acc == CntW'(1)) && st.acc_flags[sqlop_pkg::FlMd]) begin
        cls = sqlop_pkg::ClsMd;
      end else begin
        cls = sqlop_pkg::ClsOther;
      end
    end
  end

  assign state_o    = st;
  assign consumed_o = cons;
  assign accepted_o = acc;
  assign emit_o     = stop;

  assign result_o.found          = (acc != '0) && st.mask[cls];
  assign result_o.token_class    = cls;
  assign result_o.token_length   = sqlop_pkg::LenW'(acc);
  assign result_o.blanks_skipped = st.blank_count;
  assign result_o.overlong       = over;

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the SQL operator token scanner: directed and random character
// requests, a per-character token predictor and a result scoreboard.
// Depends on sqlop_pkg and sql_operator_token_scanner.
module tb;

  localparam int MaxLen     = sqlop_pkg::MaxTokenLenDefault;
  localparam int NumReqs    = 1050;
  localparam int HoldStart  = 800;
  localparam int HoldLen    = 400;
  localparam int IdleLimit  = 2000;

  typedef struct packed {
    logic       start;
    logic [7:0] ch;
    logic [3:0] mask;
  } char_req_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready_o;
  logic       start_scan = 1'b0;
  logic [7:0] char_code = 8'h00;
  logic [3:0] valid_mask = 4'h0;
  logic       out_valid_o;
  logic       out_ready = 1'b0;
  logic       found_o;
  logic [1:0] token_class_o;
  logic [5:0] token_length_o;
  logic [7:0] blanks_skipped_o;
  logic       overlong_o;

  char_req_t               pending_reqs[$];
  sqlop_pkg::scan_result_t expected_tokens[$];
  char_req_t               tx_req;
  sqlop_pkg::scan_result_t exp_tok;
  int           tx_gap = 0;
  int           tx_burst = 0;
  int           rx_cycle = 0;
  int           rx_left = 0;
  int           rx_mode = 0;
  int           idle_cycles = 0;
  int           n_errors = 0;

  // predicted scan state
  sqlop_pkg::phase_e sc_phase = sqlop_pkg::PhIdle;
  logic [6:0] sc_prev = 7'h00;
  int         sc_consumed = 0;
  int         sc_accepted = 0;
  logic       sc_special = 1'b0;
  logic [2:0] sc_pend = 3'b000;
  logic [2:0] sc_acc = 3'b000;
  logic [7:0] sc_blanks = 8'h00;
  logic [3:0] sc_mask = 4'h0;

  always #2 clk_i = ~clk_i;

  sql_operator_token_scanner DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready_o),
    .start_scan_i    (start_scan),
    .char_code_i     (char_code),
    .valid_mask_i    (valid_mask),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready),
    .found_o         (found_o),
    .token_class_o   (token_class_o),
    .token_length_o  (token_length_o),
    .blanks_skipped_o(blanks_skipped_o),
    .overlong_o      (overlong_o)
  );

  function automatic logic blank_char(input logic [7:0] c);
    return (c == sqlop_pkg::CharSpace) || (c == sqlop_pkg::CharTab) ||
           (c == sqlop_pkg::CharCr) || (c == sqlop_pkg::CharLf);
  endfunction

  function automatic logic special_char(input logic [7:0] c);
    return (c == sqlop_pkg::CharTilde) || (c == sqlop_pkg::CharBang) ||
           (c == sqlop_pkg::CharAt) || (c == sqlop_pkg::CharHash) ||
           (c == sqlop_pkg::CharPct) || (c == sqlop_pkg::CharCaret) ||
           (c == sqlop_pkg::CharAmp) || (c == sqlop_pkg::CharPipe) ||
           (c == sqlop_pkg::CharTick) || (c == sqlop_pkg::CharQuest);
  endfunction

  function automatic logic oper_char(input logic [7:0] c);
    return (c == sqlop_pkg::CharPlus) || (c == sqlop_pkg::CharMinus) ||
           (c == sqlop_pkg::CharStar) || (c == sqlop_pkg::CharSlash) ||
           (c == sqlop_pkg::CharLt) || (c == sqlop_pkg::CharGt) ||
           (c == sqlop_pkg::CharEq) || special_char(c);
  endfunction

  // advance the token predictor by one character, queue a result when the scan ends
  function automatic void lex_char(input logic st, input logic [7:0] c, input logic [3:0] m);
    logic [7:0]   last;
    logic         stop;
    logic         over;
    logic [2:0]   fl;
    logic [1:0]   cls;
    sqlop_pkg::scan_result_t r;
    stop = 1'b0;
    over = 1'b0;
    if (st) begin
      sc_phase    = sqlop_pkg::PhBlank;
      sc_prev     = 7'h00;
      sc_consumed = 0;
      sc_accepted = 0;
      sc_special  = 1'b0;
      sc_pend     = 3'b000;
      sc_acc      = 3'b000;
      sc_blanks   = 8'h00;
      sc_mask     = m;
    end
    if (sc_phase == sqlop_pkg::PhBlank && blank_char(c)) begin
      if (sc_blanks != 8'hFF) sc_blanks = sc_blanks + 8'd1;
    end else begin
      if (sc_phase == sqlop_pkg::PhBlank) sc_phase = sqlop_pkg::PhOper;
      if (sc_phase == sqlop_pkg::PhOper) begin
        last = {1'b0, sc_prev};
        if ((last == sqlop_pkg::CharMinus && c == sqlop_pkg::CharMinus) ||
            (last == sqlop_pkg::CharSlash && c == sqlop_pkg::CharStar)) begin
          // comment opener ends the run
          stop = 1'b1;
        end else begin
          if (special_char(last)) sc_special = 1'b1;
          // a longer token may not end in plus or minus without a special char
          if (sc_special ||
              !(last == sqlop_pkg::CharPlus || last == sqlop_pkg::CharMinus) ||
              sc_consumed <= 1) begin
            sc_accepted = sc_consumed;
            sc_acc      = sc_pend;
          end
          if (oper_char(c)) begin
            if (sc_consumed >= MaxLen) begin
              stop = 1'b1;
              over = 1'b1;
            end else begin
              sc_consumed = sc_consumed + 1;
              fl = 3'b000;
              if (last == sqlop_pkg::CharNul) begin
                fl[sqlop_pkg::FlCmp] = (c == sqlop_pkg::CharLt) || (c == sqlop_pkg::CharGt) ||
                                       (c == sqlop_pkg::CharEq);
              end else begin
                fl[sqlop_pkg::FlCmp] =
                    (last == sqlop_pkg::CharLt &&
                     (c == sqlop_pkg::CharEq || c == sqlop_pkg::CharGt)) ||
                    ((last == sqlop_pkg::CharBang || last == sqlop_pkg::CharGt) &&
                     c == sqlop_pkg::CharEq);
              end
              fl[sqlop_pkg::FlPm] = (c == sqlop_pkg::CharPlus) || (c == sqlop_pkg::CharMinus);
              fl[sqlop_pkg::FlMd] = (c == sqlop_pkg::CharStar) || (c == sqlop_pkg::CharSlash) ||
                                    (c == sqlop_pkg::CharPct);
              sc_pend = fl;
              sc_prev = c[6:0];
            end
          end else begin
            stop = 1'b1;
          end
        end
      end
    end
    // scan finished: classify the accepted token
    if (stop) begin
      sc_phase = sqlop_pkg::PhDone;
      r = '0;
      cls = sqlop_pkg::ClsCmp;
      if (sc_accepted > 0) begin
        if (sc_accepted <= 2 && sc_acc[sqlop_pkg::FlCmp]) cls = sqlop_pkg::ClsCmp;
        else if (sc_accepted == 1 && sc_acc[sqlop_pkg::FlPm]) cls = sqlop_pkg::ClsPm;
        else if (sc_accepted == 1 && sc_acc[sqlop_pkg::FlMd]) cls = sqlop_pkg::ClsMd;
        else cls = sqlop_pkg::ClsOther;
        r.found = sc_mask[cls];
      end
      r.token_class    = cls;
      r.token_length   = sc_accepted[5:0];
      r.blanks_skipped = sc_blanks;
      r.overlong       = over;
      expected_tokens.push_back(r);
    end
  endfunction

  function automatic logic [7:0] rand_op(input logic hot);
    logic [7:0] c;
    case (hot ? $urandom_range(17, 24) : $urandom_range(0, 16))
      0:  c = sqlop_pkg::CharTilde;
      1:  c = sqlop_pkg::CharBang;
      2:  c = sqlop_pkg::CharAt;
      3:  c = sqlop_pkg::CharHash;
      4:  c = sqlop_pkg::CharPct;
      5:  c = sqlop_pkg::CharCaret;
      6:  c = sqlop_pkg::CharAmp;
      7:  c = sqlop_pkg::CharPipe;
      8:  c = sqlop_pkg::CharTick;
      9:  c = sqlop_pkg::CharQuest;
      10: c = sqlop_pkg::CharPlus;
      11: c = sqlop_pkg::CharMinus;
      12: c = sqlop_pkg::CharStar;
      13: c = sqlop_pkg::CharSlash;
      14: c = sqlop_pkg::CharLt;
      15: c = sqlop_pkg::CharGt;
      16: c = sqlop_pkg::CharEq;
      17: c = sqlop_pkg::CharPlus;
      18: c = sqlop_pkg::CharMinus;
      19: c = sqlop_pkg::CharLt;
      20: c = sqlop_pkg::CharGt;
      21: c = sqlop_pkg::CharEq;
      22: c = sqlop_pkg::CharBang;
      23: c = sqlop_pkg::CharSlash;
      default: c = sqlop_pkg::CharStar;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] rand_blank();
    logic [7:0] c;
    case ($urandom_range(0, 3))
      0:       c = sqlop_pkg::CharSpace;
      1:       c = sqlop_pkg::CharTab;
      2:       c = sqlop_pkg::CharCr;
      default: c = sqlop_pkg::CharLf;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] rand_end();
    logic [7:0] c;
    case ($urandom_range(0, 4))
      0:       c = sqlop_pkg::CharNul;
      1:       c = 8'($urandom_range(0, 255));
      2:       c = rand_blank();
      3:       c = 8'hFF;
      default: c = 8'(8'h61 + $urandom_range(0, 25));
    endcase
    return c;
  endfunction

  task automatic push_req(input logic st, input logic [7:0] ch, input logic [3:0] m);
    char_req_t r;
    r.start = st;
    r.ch    = ch;
    r.mask  = m;
    pending_reqs.push_back(r);
  endtask

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      n_errors++;
    end
  endtask

  // driver: bursts of requests separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid   <= 1'b0;
      start_scan <= 1'b0;
      char_code  <= 8'h00;
      valid_mask <= 4'h0;
    end else begin
      if (in_valid && in_ready_o) lex_char(start_scan, char_code, valid_mask);
      if (!in_valid || in_ready_o) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          tx_req = pending_reqs.pop_front();
          in_valid   <= 1'b1;
          start_scan <= tx_req.start;
          char_code  <= tx_req.ch;
          valid_mask <= tx_req.mask;
          if (tx_burst > 0) tx_burst--;
          if (tx_burst == 0) begin
            tx_burst = $urandom_range(1, 40);
            tx_gap   = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 20) : 0;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: stall pattern, one long hold-off, result scoreboard
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      rx_cycle++;
      if (out_valid_o && out_ready) begin
        if (expected_tokens.size() == 0) begin
          $display("%0t: result with none expected, expected nothing, actual found=%0d len=%0d",
                   $time, found_o, token_length_o);
          n_errors++;
        end else begin
          exp_tok = expected_tokens.pop_front();
          check_field("found", exp_tok.found, found_o);
          check_field("token_class", exp_tok.token_class, token_class_o);
          check_field("token_length", exp_tok.token_length, token_length_o);
          check_field("blanks_skipped", exp_tok.blanks_skipped, blanks_skipped_o);
          check_field("overlong", exp_tok.overlong, overlong_o);
        end
      end
      if (rx_cycle >= HoldStart && rx_cycle < HoldStart + HoldLen) begin
        out_ready <= 1'b0;
      end else begin
        if (rx_left == 0) begin
          rx_mode = $urandom_range(0, 2);
          rx_left = $urandom_range(1, 40);
        end
        rx_left--;
        case (rx_mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 1) == 1);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no progress for %0d cycles", $time, IdleLimit);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    int         k;
    int         nb;
    int         len;
    int         pick;
    logic       first;
    logic [3:0] m;
    logic [7:0] c;
    logic [7:0] prev;

    // directed: compare pair
    push_req(1'b1, sqlop_pkg::CharLt, 4'hF);
    push_req(1'b0, sqlop_pkg::CharEq, 4'h0);
    push_req(1'b0, 8'h61, 4'hF);
    // leading blanks then a lone plus, end of input
    push_req(1'b1, sqlop_pkg::CharSpace, 4'h2);
    push_req(1'b0, sqlop_pkg::CharTab, 4'hD);
    push_req(1'b0, sqlop_pkg::CharCr, 4'h0);
    push_req(1'b0, sqlop_pkg::CharLf, 4'hF);
    push_req(1'b0, sqlop_pkg::CharPlus, 4'h5);
    push_req(1'b0, sqlop_pkg::CharNul, 4'hA);
    // comment openers
    push_req(1'b1, sqlop_pkg::CharMinus, 4'hF);
    push_req(1'b0, sqlop_pkg::CharMinus, 4'hF);
    push_req(1'b1, sqlop_pkg::CharSlash, 4'h4);
    push_req(1'b0, sqlop_pkg::CharStar, 4'h0);
    // class disabled, highest char code ends it
    push_req(1'b1, sqlop_pkg::CharStar, 4'h0);
    push_req(1'b0, 8'hFF, 4'hF);
    // character with no scan running
    push_req(1'b0, 8'h79, 4'hF);
    // special char lets the token end in plus
    push_req(1'b1, sqlop_pkg::CharTilde, 4'h8);
    push_req(1'b0, sqlop_pkg::CharPlus, 4'h0);
    push_req(1'b0, sqlop_pkg::CharNul, 4'h0);
    // trailing plus is cut back
    push_req(1'b1, sqlop_pkg::CharPlus, 4'hF);
    push_req(1'b0, sqlop_pkg::CharPlus, 4'hF);
    push_req(1'b0, sqlop_pkg::CharSpace, 4'hF);
    // no token at all
    push_req(1'b1, 8'h78, 4'hF);
    push_req(1'b1, sqlop_pkg::CharNul, 4'h0);

    // blank count saturation
    push_req(1'b1, rand_blank(), 4'hF);
    repeat (259) push_req(1'b0, rand_blank(), 4'($urandom_range(0, 15)));
    push_req(1'b0, sqlop_pkg::CharLt, 4'($urandom_range(0, 15)));
    push_req(1'b0, sqlop_pkg::CharGt, 4'($urandom_range(0, 15)));
    push_req(1'b0, rand_end(), 4'($urandom_range(0, 15)));

    // random sequences, mostly well-formed scans
    while (pending_reqs.size() < NumReqs) begin
      pick  = $urandom_range(0, 99);
      m     = 4'($urandom_range(0, 15));
      first = 1'b1;
      if (pick < 72) begin
        nb  = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
        len = $urandom_range(1, 6);
        repeat (nb) begin
          push_req(first, rand_blank(), first ? m : 4'($urandom_range(0, 15)));
          first = 1'b0;
        end
        repeat (len) begin
          push_req(first, rand_op($urandom_range(0, 1) == 1),
                   first ? m : 4'($urandom_range(0, 15)));
          first = 1'b0;
        end
        push_req(1'b0, rand_end(), 4'($urandom_range(0, 15)));
      end else if (pick < 76) begin
        // long run around the length bound, no comment opener inside
        len  = $urandom_range(MaxLen - 1, MaxLen + 3);
        prev = sqlop_pkg::CharNul;
        for (k = 0; k < len; k++) begin
          c = rand_op($urandom_range(0, 1) == 1);
          if ((prev == sqlop_pkg::CharMinus && c == sqlop_pkg::CharMinus) ||
              (prev == sqlop_pkg::CharSlash && c == sqlop_pkg::CharStar))
            c = sqlop_pkg::CharAt;
          push_req(k == 0, c, (k == 0) ? m : 4'($urandom_range(0, 15)));
          prev = c;
        end
        push_req(1'b0, rand_end(), 4'($urandom_range(0, 15)));
      end else if (pick < 90) begin
        // noise
        repeat ($urandom_range(1, 8))
          push_req($urandom_range(0, 3) == 0, 8'($urandom_range(0, 255)),
                   4'($urandom_range(0, 15)));
      end else begin
        // scan cut off by a new start
        repeat ($urandom_range(1, 4)) begin
          push_req(first, rand_op(1'b0), m);
          first = 1'b0;
        end
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() > 0 || in_valid) @(posedge clk_i);
    while (expected_tokens.size() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (n_errors == 0 && expected_tokens.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
src/sqlop_pkg.sv
src/sqlop_step.sv
src/sql_operator_token_scanner.sv
sim/tb.sv
